/* src/lj_pkg.sv */
// ----------------------------------------------------------------------------
// lj_pkg: shared constants, types and arithmetic helpers
// Widths of the port fields, register codes and saturating helpers for the
// Lennard-Jones pair force core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lj_pkg;

  localparam int MAX_PARTICLES_DEF  = 64;
  localparam int POSITION_WIDTH_DEF = 32;
  localparam int POS_W              = 32;
  localparam int FORCE_W            = 64;
  localparam int PIDX_W             = 6;
  localparam int BOX_W              = 31;
  localparam int AM_W               = 32;
  localparam int CFG_INDEX_W        = 1;
  localparam int CFG_DATA_W         = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PERIODIC = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX      = 1'b1;

  localparam logic [BOX_W-1:0] BOX_RESET = 31'd655360;

  localparam logic [63:0] SATMAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SATMIN   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic        ovf;
    logic [63:0] val;
  } sat_t;

  function automatic sat_t sadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    sat_t        r;
    s     = {a[63], a} + {b[63], b};
    r.ovf = (s[64] != s[63]);
    r.val = r.ovf ? (s[64] ? SATMIN : SATMAX) : s[63:0];
    return r;
  endfunction

  function automatic sat_t mul48(input logic [63:0] a);
    logic [68:0] p;
    sat_t        r;
    p     = ({5'b0, a} << 5) + ({5'b0, a} << 4);
    r.ovf = (p > {5'b0, SATMAX});
    r.val = r.ovf ? SATMAX : p[63:0];
    return r;
  endfunction

  function automatic sat_t mul4(input logic [63:0] a);
    sat_t r;
    r.ovf = (a[63:61] != 3'b0);
    r.val = r.ovf ? SATMAX : {a[61:0], 2'b0};
    return r;
  endfunction

  function automatic logic [63:0] apply_sign(input logic [63:0] mag, input logic neg);
    return neg ? (64'd0 - mag) : mag;
  endfunction

endpackage

`default_nettype wire

/* src/lennard_jones_pair_forces_core.sv */
// ----------------------------------------------------------------------------
// lennard_jones_pair_forces_core: Lennard-Jones forces with minimum image
// Loads positions, then walks all pairs i<j and emits one force per particle.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (pos_x/y/z, last) are taken one per cycle while the core is
//   loading. The beat with last set starts the compute phase; in_ready stays
//   low until the final result beat has been taken.
//   Compute walks every pair i<j once, N(N-1)/2 pairs for N particles. A
//   pair uses up to three 34-step folds and one 64-step reciprocal on the
//   shared bit-serial divider, eight 4-pass Q32.32 multiplies on one 32x32
//   multiplier, and six read-modify-write updates on the force memories.
//   Results leave in load order on out_valid/out_ready; a stalled receiver
//   simply holds the current beat. total_energy is nonzero only on the beat
//   with last_result set.
//   Configuration beats (cfg_index, cfg_data) are taken every cycle.
//   Reset clears the particle count, energy and flag, and restores
//   periodic_enable = 1 and box_side = 10.0. Force entries carry valid bits
//   that are all cleared together when the last beat is taken, so no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lennard_jones_pair_forces_core #(
  parameter int MAX_PARTICLES  = lj_pkg::MAX_PARTICLES_DEF,
  parameter int POSITION_WIDTH = lj_pkg::POSITION_WIDTH_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire signed [lj_pkg::POS_W-1:0]         pos_x,
  input  wire signed [lj_pkg::POS_W-1:0]         pos_y,
  input  wire signed [lj_pkg::POS_W-1:0]         pos_z,
  input  wire                                    last,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic [lj_pkg::PIDX_W-1:0]              particle_index,
  output logic signed [lj_pkg::FORCE_W-1:0]      force_x,
  output logic signed [lj_pkg::FORCE_W-1:0]      force_y,
  output logic signed [lj_pkg::FORCE_W-1:0]      force_z,
  output logic signed [lj_pkg::FORCE_W-1:0]      total_energy,
  output logic                                   overflow,
  output logic                                   last_result,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [lj_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  wire [lj_pkg::CFG_DATA_W-1:0]           cfg_data
);
  import lj_pkg::*;

  localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int PW = POSITION_WIDTH;

  localparam logic [4:0] S_LOAD      = 5'd0;
  localparam logic [4:0] S_PAIR_RD   = 5'd1;
  localparam logic [4:0] S_DIFF      = 5'd2;
  localparam logic [4:0] S_FOLD_LD   = 5'd3;
  localparam logic [4:0] S_FOLD_DIV  = 5'd4;
  localparam logic [4:0] S_FOLD_END  = 5'd5;
  localparam logic [4:0] S_FAR       = 5'd6;
  localparam logic [4:0] S_SQ        = 5'd7;
  localparam logic [4:0] S_RECIP_LD  = 5'd8;
  localparam logic [4:0] S_RECIP_DIV = 5'd9;
  localparam logic [4:0] S_RECIP_END = 5'd10;
  localparam logic [4:0] S_MQ_LD     = 5'd11;
  localparam logic [4:0] S_MQ        = 5'd12;
  localparam logic [4:0] S_MQ_END    = 5'd13;
  localparam logic [4:0] S_FRD       = 5'd14;
  localparam logic [4:0] S_FWI       = 5'd15;
  localparam logic [4:0] S_FWJ       = 5'd16;
  localparam logic [4:0] S_NEXT      = 5'd17;
  localparam logic [4:0] S_OUT_RD    = 5'd18;
  localparam logic [4:0] S_OUT_LD    = 5'd19;
  localparam logic [4:0] S_OUT_WAIT  = 5'd20;

  // multiply program steps
  localparam logic [2:0] MS_SQR  = 3'd0;
  localparam logic [2:0] MS_CUBE = 3'd1;
  localparam logic [2:0] MS_F1   = 3'd2;
  localparam logic [2:0] MS_F2   = 3'd3;
  localparam logic [2:0] MS_E    = 3'd4;
  localparam logic [2:0] MS_FX   = 3'd5;
  localparam logic [2:0] MS_FY   = 3'd6;
  localparam logic [2:0] MS_FZ   = 3'd7;

  logic [4:0]          state;
  logic [CW-1:0]       count;
  logic [IW-1:0]       pi;
  logic [IW-1:0]       pj;
  logic                periodic;
  logic [BOX_W-1:0]    box;
  logic [63:0]         energy;
  logic                ovf;

  logic [PW-1:0]       pos_mem [3][MAX_PARTICLES];
  logic [PW-1:0]       pos_rd_i [3];
  logic [PW-1:0]       pos_rd_j [3];

  logic [63:0]         force_mem [3][MAX_PARTICLES];
  logic [MAX_PARTICLES-1:0] fvalid [3];
  logic [63:0]         f_rd_i [3];
  logic [63:0]         f_rd_j [3];
  logic                f_vi [3];
  logic                f_vj [3];
  logic [63:0]         val_i [3];
  logic [63:0]         val_j [3];

  logic [AM_W-1:0]     mag [3];
  logic                dneg [3];
  logic [1:0]          k;
  logic [2:0]          step;
  logic [2:0]          ms;

  logic [63:0]         div_num;
  logic [63:0]         div_rem;
  logic [63:0]         div_quo;
  logic [63:0]         div_den;
  logic [6:0]          div_cnt;
  logic [64:0]         rem_sh;
  logic                div_ge;

  logic [63:0]         r2;
  logic [63:0]         inv2;
  logic [63:0]         r6;
  logic [63:0]         tmp;
  logic [63:0]         fmag;
  logic [63:0]         comp;
  logic [63:0]         mq_a;
  logic [63:0]         mq_b;
  logic [65:0]         acc;
  logic                big;
  logic [31:0]         mul_x;
  logic [31:0]         mul_y;
  logic [63:0]         prod;

  logic                pos_we;
  logic                pos_re;
  logic                f_re;
  logic                f_we;
  logic [IW-1:0]       f_waddr;
  logic [1:0]          ck;
  logic [63:0]         comp_s;
  sat_t                f_sum;
  logic [IW-1:0]       f_raddr;

  logic                fneg;
  logic                eneg;
  logic [63:0]         tf;
  logic [63:0]         te;
  logic                mq_sat;
  logic [63:0]         mq_res;
  sat_t                m48;
  sat_t                m4;
  sat_t                e_sum;

  logic [CW-1:0]       count_next;
  logic                fold_on;

  assign in_ready  = (state == S_LOAD);
  assign cfg_ready = 1'b1;

  assign pos_we  = (state == S_LOAD) && in_valid && (count < CW'(MAX_PARTICLES));
  assign pos_re  = (state == S_PAIR_RD);
  assign f_re    = (state == S_FRD) || (state == S_OUT_RD);
  assign f_we    = (state == S_FWI) || (state == S_FWJ);
  assign f_waddr = (state == S_FWI) ? pi : pj;
  assign f_raddr = pi;
  assign ck      = 2'(ms - MS_FX);
  assign fold_on = periodic && (box != '0);
  assign count_next = count + CW'(count < CW'(MAX_PARTICLES));

  assign fneg = (r6 < HALF_Q32);
  assign eneg = (r6 < ONE_Q32);
  assign tf   = fneg ? (HALF_Q32 - r6) : (r6 - HALF_Q32);
  assign te   = eneg ? (ONE_Q32 - r6) : (r6 - ONE_Q32);

  assign rem_sh = {div_rem, div_num[63]};
  assign div_ge = (rem_sh >= {1'b0, div_den});

  assign mq_sat = big || (acc[65:63] != 3'b0);
  assign mq_res = mq_sat ? SATMAX : {1'b0, acc[62:0]};
  assign m48    = mul48(mq_res);
  assign m4     = mul4(mq_res);
  assign e_sum  = sadd(energy, apply_sign(m4.val, eneg));

  assign comp_s = apply_sign(comp, fneg ^ dneg[ck]);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      val_i[c] = f_vi[c] ? f_rd_i[c] : 64'd0;
      val_j[c] = f_vj[c] ? f_rd_j[c] : 64'd0;
    end
    if (state == S_FWI) begin
      f_sum = sadd(val_i[ck], comp_s);
    end else begin
      f_sum = sadd(val_j[ck], 64'd0 - comp_s);
    end
  end

  always_comb begin
    if (state == S_SQ) begin
      mul_x = mag[step[1:0]];
      mul_y = mag[step[1:0]];
    end else begin
      case (step)
        3'd0:    begin mul_x = mq_a[63:32]; mul_y = mq_b[63:32]; end
        3'd1:    begin mul_x = mq_a[63:32]; mul_y = mq_b[31:0];  end
        3'd2:    begin mul_x = mq_a[31:0];  mul_y = mq_b[63:32]; end
        default: begin mul_x = mq_a[31:0];  mul_y = mq_b[31:0];  end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  // position memories
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[0][IW'(count)] <= pos_x[PW-1:0];
      pos_mem[1][IW'(count)] <= pos_y[PW-1:0];
      pos_mem[2][IW'(count)] <= pos_z[PW-1:0];
    end
    if (pos_re) begin
      for (int c = 0; c < 3; c++) begin
        pos_rd_i[c] <= pos_mem[c][pi];
        pos_rd_j[c] <= pos_mem[c][pj];
      end
    end
  end

  // force memories
  always_ff @(posedge clk) begin
    if (f_we) begin
      force_mem[ck][f_waddr] <= f_sum.val;
    end
    if (f_re) begin
      for (int c = 0; c < 3; c++) begin
        f_rd_i[c] <= force_mem[c][f_raddr];
        f_rd_j[c] <= force_mem[c][pj];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        fvalid[c] <= '0;
      end
    end else if ((state == S_LOAD) && in_valid && last) begin
      for (int c = 0; c < 3; c++) begin
        fvalid[c] <= '0;
      end
    end else if (f_we) begin
      fvalid[ck][f_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (f_re) begin
      for (int c = 0; c < 3; c++) begin
        f_vi[c] <= fvalid[c][f_raddr];
        f_vj[c] <= fvalid[c][pj];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic <= 1'b1;
      box      <= BOX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PERIODIC: periodic <= cfg_data[0];
        REG_BOX:      box      <= cfg_data[BOX_W-1:0];
        default:      ;
      endcase
    end
  end

  // divider step, shared by folds and the reciprocal
  always_ff @(posedge clk) begin
    if (state == S_FOLD_LD) begin
      div_num <= {({1'b0, mag[k], 1'b0} + {3'b0, box}), 30'b0};
      div_den <= {32'b0, box, 1'b0};
      div_rem <= '0;
      div_cnt <= 7'd34;
    end else if (state == S_RECIP_LD) begin
      div_num <= '1;
      div_den <= r2;
      div_rem <= '0;
      div_cnt <= 7'd64;
    end else if ((state == S_FOLD_DIV) || (state == S_RECIP_DIV)) begin
      div_rem <= div_ge ? 64'(rem_sh - {1'b0, div_den}) : rem_sh[63:0];
      div_quo <= {div_quo[62:0], div_ge};
      div_num <= {div_num[62:0], 1'b0};
      div_cnt <= div_cnt - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      energy    <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      pi        <= '0;
      pj        <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            count <= count_next;
            if (!(count < CW'(MAX_PARTICLES))) begin
              ovf <= 1'b1;
            end
            if (last) begin
              energy <= '0;
              pi     <= '0;
              pj     <= IW'(1);
              state  <= (count_next >= CW'(2)) ? S_PAIR_RD : S_OUT_RD;
            end
          end
        end
        S_PAIR_RD: state <= S_DIFF;
        S_DIFF: begin
          for (int c = 0; c < 3; c++) begin
            logic [PW:0] d;
            d = {pos_rd_i[c][PW-1], pos_rd_i[c]} - {pos_rd_j[c][PW-1], pos_rd_j[c]};
            dneg[c] <= d[PW];
            mag[c]  <= AM_W'(d[PW] ? ((PW+1)'(0) - d) : d);
          end
          k     <= '0;
          state <= fold_on ? S_FOLD_LD : S_FAR;
        end
        S_FOLD_LD: state <= S_FOLD_DIV;
        S_FOLD_DIV: begin
          if (div_cnt == 7'd1) begin
            state <= S_FOLD_END;
          end
        end
        S_FOLD_END: begin
          logic [33:0] diff;
          logic [33:0] fm;
          diff = {1'b0, div_rem[32:0]} - {3'b0, box};
          fm   = diff[33] ? (34'd0 - diff) : diff;
          mag[k]  <= AM_W'(fm[33:1]);
          dneg[k] <= (fm[33:1] != '0) && (dneg[k] ^ diff[33]);
          if (k == 2'd2) begin
            state <= S_FAR;
          end else begin
            k     <= k + 2'd1;
            state <= S_FOLD_LD;
          end
        end
        S_FAR: begin
          r2   <= '0;
          step <= '0;
          if (mag[0][AM_W-1] || mag[1][AM_W-1] || mag[2][AM_W-1]) begin
            state <= S_NEXT;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (step != 3'd0) begin
            r2 <= r2 + prod;
          end
          step <= step + 3'd1;
          if (step == 3'd3) begin
            state <= S_RECIP_LD;
          end
        end
        S_RECIP_LD: begin
          ms <= MS_SQR;
          if (r2 <= 64'd1) begin
            ovf   <= 1'b1;
            inv2  <= SATMAX;
            state <= S_MQ_LD;
          end else begin
            state <= S_RECIP_DIV;
          end
        end
        S_RECIP_DIV: begin
          if (div_cnt == 7'd1) begin
            state <= S_RECIP_END;
          end
        end
        S_RECIP_END: begin
          inv2  <= (div_rem == r2 - 64'd1) ? div_quo + 64'd1 : div_quo;
          state <= S_MQ_LD;
        end
        S_MQ_LD: begin
          case (ms)
            MS_SQR:  begin mq_a <= inv2; mq_b <= inv2; end
            MS_CUBE: begin mq_a <= tmp;  mq_b <= inv2; end
            MS_F1:   begin mq_a <= inv2; mq_b <= r6;   end
            MS_F2:   begin mq_a <= tmp;  mq_b <= tf;   end
            MS_E:    begin mq_a <= r6;   mq_b <= te;   end
            default: begin mq_a <= fmag; mq_b <= {16'b0, mag[ck], 16'b0}; end
          endcase
          acc   <= '0;
          big   <= 1'b0;
          step  <= '0;
          state <= S_MQ;
        end
        S_MQ: begin
          case (step)
            3'd1: begin
              big <= (prod[63:31] != '0);
              acc <= acc + {3'b0, prod[30:0], 32'b0};
            end
            3'd2, 3'd3: acc <= acc + {2'b0, prod};
            3'd4: acc <= acc + {34'b0, prod[63:32]};
            default: ;
          endcase
          step <= step + 3'd1;
          if (step == 3'd4) begin
            state <= S_MQ_END;
          end
        end
        S_MQ_END: begin
          if (mq_sat) begin
            ovf <= 1'b1;
          end
          case (ms)
            MS_SQR: begin
              tmp <= mq_res; ms <= MS_CUBE; state <= S_MQ_LD;
            end
            MS_CUBE: begin
              r6 <= mq_res; ms <= MS_F1; state <= S_MQ_LD;
            end
            MS_F1: begin
              tmp <= mq_res; ms <= MS_F2; state <= S_MQ_LD;
            end
            MS_F2: begin
              fmag <= m48.val;
              if (m48.ovf) begin
                ovf <= 1'b1;
              end
              ms    <= MS_E;
              state <= S_MQ_LD;
            end
            MS_E: begin
              energy <= e_sum.val;
              if (m4.ovf || e_sum.ovf) begin
                ovf <= 1'b1;
              end
              ms    <= MS_FX;
              state <= S_MQ_LD;
            end
            default: begin
              comp  <= mq_res;
              state <= S_FRD;
            end
          endcase
        end
        S_FRD: state <= S_FWI;
        S_FWI: begin
          if (f_sum.ovf) begin
            ovf <= 1'b1;
          end
          state <= S_FWJ;
        end
        S_FWJ: begin
          if (f_sum.ovf) begin
            ovf <= 1'b1;
          end
          if (ms == MS_FZ) begin
            state <= S_NEXT;
          end else begin
            ms    <= ms + 3'd1;
            state <= S_MQ_LD;
          end
        end
        S_NEXT: begin
          if (CW'(pj) == count - CW'(1)) begin
            if (CW'(pi) == count - CW'(2)) begin
              pi    <= '0;
              state <= S_OUT_RD;
            end else begin
              pi    <= pi + IW'(1);
              pj    <= pi + IW'(2);
              state <= S_PAIR_RD;
            end
          end else begin
            pj    <= pj + IW'(1);
            state <= S_PAIR_RD;
          end
        end
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          particle_index <= PIDX_W'(pi);
          force_x        <= val_i[0];
          force_y        <= val_i[1];
          force_z        <= val_i[2];
          last_result    <= (CW'(pi) == count - CW'(1));
          total_energy   <= (CW'(pi) == count - CW'(1)) ? energy : 64'd0;
          overflow       <= ovf;
          out_valid      <= 1'b1;
          state          <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (CW'(pi) == count - CW'(1)) begin
              count  <= '0;
              energy <= '0;
              ovf    <= 1'b0;
              state  <= S_LOAD;
            end else begin
              pi    <= pi + IW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("input taken while a result beat is pending");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAIR_RD) |-> ((pj > pi) && (CW'(pj) < count)))
    else $error("pair indices out of order or range");

  a_force_write_range: assert property (@(posedge clk) disable iff (rst)
    f_we |-> (CW'(f_waddr) < count))
    else $error("force write beyond loaded particles");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_result) |-> (CW'(pi) == count - CW'(1)))
    else $error("last_result on a beat that is not the final one");

  a_valid_in_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT_WAIT))
    else $error("result beat valid outside the output wait");

endmodule

`default_nettype wire
